### sv/prefetch_queue_bus_unit_defines.svh
// Assertion macros for the prefetch queue bus unit.
// No dependencies; included by the top level.
`ifndef PREFETCH_QUEUE_BUS_UNIT_DEFINES_SVH
`define PREFETCH_QUEUE_BUS_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define PQBU_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pqbu assertion failed");

// Next-cycle implication, disabled while reset is high.
`define PQBU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pqbu assertion failed");

`endif

### sv/pqbu_pkg.sv
// Shared types and constants of the prefetch queue bus unit.
// No dependencies; used by pqbu_queue and prefetch_queue_bus_unit.
package pqbu_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int HEAD_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int SUM_W       = $clog2(2 * QUEUE_DEPTH);

   typedef enum logic [1:0] {
      CMD_TICK    = 2'd0,
      CMD_SUSPEND = 2'd1,
      CMD_FLUSH   = 2'd2,
      CMD_POP     = 2'd3
   } command_type;

   localparam logic [1:0] PHASE_IDLE   = 2'd0;
   localparam logic [1:0] PHASE_SCHED0 = 2'd1;
   localparam logic [1:0] PHASE_SCHED1 = 2'd2;
   localparam logic [1:0] PHASE_SCHED2 = 2'd3;

   localparam logic [2:0] TSTATE_IDLE = 3'd0;
   localparam logic [2:0] TSTATE_T1   = 3'd1;
   localparam logic [2:0] TSTATE_T2   = 3'd2;
   localparam logic [2:0] TSTATE_T3   = 3'd3;
   localparam logic [2:0] TSTATE_T4   = 3'd4;

   localparam logic STATUS_PASSIVE = 1'b0;
   localparam logic STATUS_CODE    = 1'b1;

   typedef struct packed {
      command_type command;
      logic [15:0] code_segment;
      logic [15:0] instr_pointer;
      logic [7:0]  read_byte;
   } req_type;

   typedef struct packed {
      logic [19:0] mem_address;
      logic        mem_read;
      logic        ip_advance;
      logic        pop_valid;
      logic [7:0]  pop_byte;
      logic [2:0]  queue_count;
      logic        bus_status;
      logic [2:0]  bus_tstate;
      logic [1:0]  fetch_phase;
   } rsp_type;

   typedef struct packed {
      logic push;
      logic pop;
      logic flush;
   } queue_ctrl_type;

   typedef struct packed {
      logic [FILL_W-1:0] fill;
      logic [FILL_W-1:0] fill_next;
      logic [7:0]        head_byte;
   } queue_stat_type;

endpackage

### sv/prefetch_queue_bus_unit.sv
// Top level of the prefetch queue bus unit: fetch sequencer and result buffer.
// Depends on pqbu_pkg, pqbu_queue and prefetch_queue_bus_unit_defines.svh.
//
//   channel   ports                          word type          direction
//   request   req_valid req_stall req_word   pqbu_pkg::req_type  in
//   response  rsp_valid rsp_stall rsp_word   pqbu_pkg::rsp_type  out
//
// Each accepted word is processed at its accepting edge: sequencer and queue registers update
// and the result word enters a two-entry output buffer, so one word per cycle is sustained
// while responses are taken; each response is presented from the registered output buffer.
// Reset is synchronous and active high; it idles the sequencer and empties the queue and the
// output buffer. Queue storage itself is not cleared.
// A stalled response holds in the buffer; requests stall only when both entries are occupied.
`include "prefetch_queue_bus_unit_defines.svh"

module prefetch_queue_bus_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  pqbu_pkg::req_type req_word,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output pqbu_pkg::rsp_type rsp_word
);

   // Fetch sequencer registers.
   logic [1:0] phase_ff, phase_in;
   logic [2:0] tstate_ff, tstate_in;
   logic       status_ff, status_in;
   logic       suspended_ff, suspended_in;
   logic       scheduled_ff, scheduled_in;

   // Output buffer: two entries, read and write pointers and an occupancy count.
   pqbu_pkg::rsp_type buf_ff [2];
   logic              wr_ptr_ff, rd_ptr_ff;
   logic [1:0]        count_ff, count_in;

   logic req_accept;
   logic rsp_take;
   logic fetched;
   logic pop_ok;
   logic t4_tick;
   logic phase_busy;
   logic seq_idle;
   logic buf_grow;

   pqbu_pkg::queue_ctrl_type queue_ctrl;
   pqbu_pkg::queue_stat_type queue_stat;
   pqbu_pkg::rsp_type        result;

   assign req_stall  = (count_ff == 2'd2);
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = (count_ff != 2'd0);
   assign rsp_take   = rsp_valid && !rsp_stall;

   pqbu_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (queue_ctrl),
      .push_byte (req_word.read_byte),
      .stat      (queue_stat)
   );

   // A tick that finds the bus in T4 of the last phase completes the fetch.
   assign t4_tick = req_accept && (req_word.command == pqbu_pkg::CMD_TICK) &&
                    !suspended_ff && (phase_ff == pqbu_pkg::PHASE_SCHED2) &&
                    (tstate_ff == pqbu_pkg::TSTATE_T4);

   // Command decode and the sequencer's next state.
   always_comb begin
      phase_in     = phase_ff;
      tstate_in    = tstate_ff;
      status_in    = status_ff;
      suspended_in = suspended_ff;
      scheduled_in = scheduled_ff;
      queue_ctrl   = '0;
      fetched      = 1'b0;
      pop_ok       = 1'b0;
      if (req_accept) begin
         unique case (req_word.command)
            pqbu_pkg::CMD_TICK: begin
               if (!suspended_ff) begin
                  // A fresh fetch is scheduled only when the queue has room.
                  if (!scheduled_ff && (phase_ff == pqbu_pkg::PHASE_IDLE) &&
                      (queue_stat.fill <
                       pqbu_pkg::FILL_W'(pqbu_pkg::QUEUE_DEPTH))) begin
                     phase_in     = pqbu_pkg::PHASE_SCHED0;
                     tstate_in    = pqbu_pkg::TSTATE_T1;
                     scheduled_in = 1'b1;
                  end else begin
                     unique case (phase_ff)
                        pqbu_pkg::PHASE_SCHED0: begin
                           phase_in = pqbu_pkg::PHASE_SCHED1;
                        end
                        pqbu_pkg::PHASE_SCHED1: begin
                           phase_in  = pqbu_pkg::PHASE_SCHED2;
                           status_in = pqbu_pkg::STATUS_CODE;
                        end
                        pqbu_pkg::PHASE_SCHED2: begin
                           unique case (tstate_ff)
                              pqbu_pkg::TSTATE_T1: begin
                                 tstate_in = pqbu_pkg::TSTATE_T2;
                              end
                              pqbu_pkg::TSTATE_T2: begin
                                 tstate_in = pqbu_pkg::TSTATE_T3;
                                 status_in = pqbu_pkg::STATUS_PASSIVE;
                              end
                              pqbu_pkg::TSTATE_T3: begin
                                 tstate_in = pqbu_pkg::TSTATE_T4;
                              end
                              pqbu_pkg::TSTATE_T4: begin
                                 status_in       = pqbu_pkg::STATUS_PASSIVE;
                                 tstate_in       = pqbu_pkg::TSTATE_IDLE;
                                 phase_in        = pqbu_pkg::PHASE_IDLE;
                                 scheduled_in    = 1'b0;
                                 queue_ctrl.push = 1'b1;
                                 fetched         = 1'b1;
                              end
                              default: begin
                                 // An idle bus after a flush restarts at T1.
                                 tstate_in = pqbu_pkg::TSTATE_T1;
                              end
                           endcase
                        end
                        default: begin
                        end
                     endcase
                  end
               end
            end
            pqbu_pkg::CMD_SUSPEND: begin
               suspended_in = 1'b1;
            end
            pqbu_pkg::CMD_FLUSH: begin
               // The phase and the scheduled flag survive a flush.
               queue_ctrl.flush = 1'b1;
               tstate_in        = pqbu_pkg::TSTATE_IDLE;
               suspended_in     = 1'b0;
            end
            pqbu_pkg::CMD_POP: begin
               queue_ctrl.pop = 1'b1;
               pop_ok         = (queue_stat.fill != '0);
            end
            default: begin
            end
         endcase
      end
   end

   // Result word as seen after the command has taken effect.
   always_comb begin
      result.mem_address = {req_word.code_segment, 4'b0000} +
                           {4'b0000, req_word.instr_pointer};
      result.mem_read    = fetched;
      result.ip_advance  = fetched;
      result.pop_valid   = pop_ok;
      result.pop_byte    = pop_ok ? queue_stat.head_byte : 8'h00;
      result.queue_count = 3'(queue_stat.fill_next);
      result.bus_status  = status_in;
      result.bus_tstate  = tstate_in;
      result.fetch_phase = phase_in;
   end

   always_comb begin
      count_in = count_ff;
      unique case ({req_accept, rsp_take})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= pqbu_pkg::PHASE_IDLE;
         tstate_ff    <= pqbu_pkg::TSTATE_IDLE;
         status_ff    <= pqbu_pkg::STATUS_PASSIVE;
         suspended_ff <= 1'b0;
         scheduled_ff <= 1'b0;
         wr_ptr_ff    <= 1'b0;
         rd_ptr_ff    <= 1'b0;
         count_ff     <= 2'd0;
      end else begin
         phase_ff     <= phase_in;
         tstate_ff    <= tstate_in;
         status_ff    <= status_in;
         suspended_ff <= suspended_in;
         scheduled_ff <= scheduled_in;
         count_ff     <= count_in;
         if (req_accept) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (rsp_take) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         buf_ff[wr_ptr_ff] <= result;
      end
   end

   assign rsp_word = buf_ff[rd_ptr_ff];

   // Terms used by the checks below.
   assign phase_busy = (phase_ff != pqbu_pkg::PHASE_IDLE);
   assign seq_idle   = (phase_ff == pqbu_pkg::PHASE_IDLE) && !scheduled_ff &&
                       (tstate_ff == pqbu_pkg::TSTATE_IDLE);
   assign buf_grow   = req_accept && !rsp_take;

   // A fetch in flight always has a phase other than idle.
   `PQBU_ASSERT_NOW(a_sched_has_phase, clock, reset, scheduled_ff, phase_busy)
   // Completing T4 returns the sequencer to idle and clears the schedule.
   `PQBU_ASSERT_NEXT(a_t4_idles, clock, reset, t4_tick, seq_idle)
   // An accepted word that is not matched by a take occupies one more entry.
   `PQBU_ASSERT_NEXT(a_buf_grows, clock, reset, buf_grow, count_ff == $past(count_ff) + 2'd1)

endmodule

### sv/pqbu_queue.sv
// Circular byte queue of the prefetch unit: storage, head pointer and fill count.
// Depends on pqbu_pkg.
module pqbu_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  pqbu_pkg::queue_ctrl_type  ctrl,
   input  logic [7:0]                push_byte,
   output pqbu_pkg::queue_stat_type  stat
);

   logic [7:0]                  mem_ff [pqbu_pkg::QUEUE_DEPTH];
   logic [pqbu_pkg::HEAD_W-1:0] head_ff, head_in;
   logic [pqbu_pkg::FILL_W-1:0] fill_ff, fill_in;
   logic [pqbu_pkg::SUM_W-1:0]  tail_sum;
   logic [pqbu_pkg::HEAD_W-1:0] tail_idx;
   logic                        write_en;

   // Tail is head plus fill, folded back once into the queue range.
   always_comb begin
      tail_sum = pqbu_pkg::SUM_W'(head_ff) + pqbu_pkg::SUM_W'(fill_ff);
      if (tail_sum >= pqbu_pkg::SUM_W'(pqbu_pkg::QUEUE_DEPTH)) begin
         tail_sum = tail_sum - pqbu_pkg::SUM_W'(pqbu_pkg::QUEUE_DEPTH);
      end
      tail_idx = pqbu_pkg::HEAD_W'(tail_sum);
   end

   always_comb begin
      head_in  = head_ff;
      fill_in  = fill_ff;
      write_en = 1'b0;
      priority if (ctrl.flush) begin
         head_in = '0;
         fill_in = '0;
      end else if (ctrl.pop && (fill_ff != '0)) begin
         head_in = (head_ff == pqbu_pkg::HEAD_W'(pqbu_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : head_ff + pqbu_pkg::HEAD_W'(1);
         fill_in = fill_ff - pqbu_pkg::FILL_W'(1);
      end else if (ctrl.push &&
                   (fill_ff < pqbu_pkg::FILL_W'(pqbu_pkg::QUEUE_DEPTH))) begin
         // A push onto a full queue drops the byte.
         fill_in  = fill_ff + pqbu_pkg::FILL_W'(1);
         write_en = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         fill_ff <= '0;
      end else begin
         head_ff <= head_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (write_en) begin
         mem_ff[tail_idx] <= push_byte;
      end
   end

   assign stat.fill      = fill_ff;
   assign stat.fill_next = fill_in;
   assign stat.head_byte = mem_ff[head_ff];

endmodule
